// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the terminal key escape decoder.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TKED_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TKED_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tked_pkg.sv
// Shared types and byte constants for the terminal key escape decoder.
// No dependencies; imported by tked_decode and the top level.
package tked_pkg;

  localparam logic [7:0] EscByte     = 8'h1b;
  localparam logic [7:0] BracketByte = 8'h5b;
  localparam logic [7:0] TildeByte   = 8'h7e;
  localparam logic [7:0] DigitOne    = 8'h31;
  localparam logic [7:0] DigitTwo    = 8'h32;
  localparam logic [7:0] PrintLow    = 8'h20;
  localparam logic [7:0] TabByte     = 8'h09;
  localparam logic [7:0] CrByte      = 8'h0d;
  localparam logic [7:0] PercentByte = 8'h25;
  localparam logic [7:0] DelByte     = 8'h7f;

  localparam logic [7:0] KcF1   = 8'd128;
  localparam logic [7:0] KcUp   = 8'd140;
  localparam logic [7:0] KcHome = 8'd144;
  localparam logic [7:0] KcBksp = 8'd8;

  typedef enum logic [1:0] {
    EV_CHAR = 2'd0,
    EV_DOWN = 2'd1,
    EV_UP   = 2'd2
  } ev_kind_t;

  typedef struct packed {
    logic       special_pending;
    logic       bracket_seen;
    logic       expect_low_fn;
    logic       expect_mid_fn;
    logic       expect_high_fn;
    logic       tilde_mid_fn;
    logic       tilde_high_fn;
    logic       tilde_maybe_page;
    logic [7:0] held_digit;
  } tked_state_t;

  typedef struct packed {
    logic       emit;
    logic       has_char;
    logic [7:0] code;
  } tked_rec_t;

endpackage

// File: rtl/tked_decode.sv
// Combinational byte decoder: next sequence flags and the key record for one byte.
// Depends on tked_pkg.
module tked_decode import tked_pkg::*; (
  input  tked_state_t st,
  input  logic [7:0]  rx_byte,
  output tked_state_t st_next,
  output tked_rec_t   rec
);

  function automatic logic [7:0] plain_code(input logic [7:0] b);
    if (b == TabByte || b == CrByte || b == EscByte) return b;
    if (b == DelByte) return KcBksp;
    if (b >= PrintLow && b <= TildeByte && b != PercentByte) return b;
    return 8'd0;
  endfunction

  function automatic logic [7:0] fn_low_code(input logic [7:0] b);
    if (b >= 8'h41 && b <= 8'h45) return KcF1 + (b - 8'h41);
    return 8'd0;
  endfunction

  function automatic logic [7:0] fn_mid_code(input logic [7:0] b);
    if (b >= 8'h37 && b <= 8'h39) return KcF1 + 8'd5 + (b - 8'h37);
    return 8'd0;
  endfunction

  function automatic logic [7:0] fn_high_code(input logic [7:0] b);
    priority case (b)
      8'h30:   return KcF1 + 8'd8;
      8'h31:   return KcF1 + 8'd9;
      8'h33:   return KcF1 + 8'd10;
      8'h34:   return KcF1 + 8'd11;
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] arrow_code(input logic [7:0] b);
    if (b >= 8'h41 && b <= 8'h44) return KcUp + (b - 8'h41);
    return 8'd0;
  endfunction

  function automatic logic [7:0] page_code(input logic [7:0] b);
    if (b >= 8'h31 && b <= 8'h36) return KcHome + (b - 8'h31);
    return 8'd0;
  endfunction

  logic [7:0] code;
  logic [7:0] pcode;

  always_comb begin
    st_next = st;
    code    = 8'd0;
    pcode   = plain_code(rx_byte);
    rec     = '0;
    if (st.special_pending) begin
      if (rx_byte == BracketByte && !st.bracket_seen) begin
        st_next.bracket_seen = 1'b1;
      end else begin
        st_next.bracket_seen = 1'b0;
        if (rx_byte == BracketByte) begin
          st_next.expect_low_fn = 1'b1;
        end else if (rx_byte == TildeByte) begin
          st_next.special_pending = 1'b0;
          priority if (st.tilde_mid_fn) begin
            st_next.tilde_mid_fn = 1'b0;
            code = fn_mid_code(st.held_digit);
          end else if (st.tilde_high_fn) begin
            st_next.tilde_high_fn = 1'b0;
            code = fn_high_code(st.held_digit);
          end else if (st.tilde_maybe_page) begin
            st_next.tilde_maybe_page = 1'b0;
            st_next.expect_mid_fn    = 1'b0;
            st_next.expect_high_fn   = 1'b0;
            code = page_code(st.held_digit);
          end else begin
            code = 8'd0;
          end
        end else if (rx_byte[6]) begin
          st_next.special_pending = 1'b0;
          if (st.expect_low_fn) begin
            st_next.expect_low_fn = 1'b0;
            code = fn_low_code(rx_byte);
          end else begin
            code = arrow_code(rx_byte);
          end
        end else begin
          st_next.held_digit = rx_byte;
          priority if (st.expect_mid_fn) begin
            st_next.expect_mid_fn = 1'b0;
            st_next.tilde_mid_fn  = 1'b1;
          end else if (st.expect_high_fn) begin
            st_next.expect_high_fn = 1'b0;
            st_next.tilde_high_fn  = 1'b1;
          end else begin
            st_next.tilde_maybe_page = 1'b1;
            if (rx_byte == DigitOne) st_next.expect_mid_fn = 1'b1;
            else if (rx_byte == DigitTwo) st_next.expect_high_fn = 1'b1;
          end
        end
      end
      rec.emit     = (code != 8'd0);
      rec.has_char = 1'b0;
      rec.code     = code;
    end else if (!rx_byte[7] && pcode != 8'd0) begin
      if (rx_byte == EscByte) begin
        st_next.special_pending = 1'b1;
      end else begin
        rec.emit     = 1'b1;
        rec.has_char = (rx_byte >= PrintLow && rx_byte <= TildeByte);
        rec.code     = pcode;
      end
    end
  end

endmodule

// File: rtl/terminal_key_escape_decoder.sv
// A byte that gives no event does not occupy the block; bytes may arrive every cycle
// while no events are pending. A byte that decodes to a key gives two events (key
// down, key up), and a printable byte three (char, key down, key up). These go out
// one per cycle while out_stall is low, from a single result register. The next byte
// is taken in the same cycle as the last event of the previous one leaves.
// Top level of the terminal key escape decoder; depends on tked_pkg, tked_decode and
// assert_macros.svh.
`include "assert_macros.svh"

module terminal_key_escape_decoder import tked_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] event_kind,
  output logic [7:0] key_code,
  output logic       last_event
);

  tked_state_t st;
  tked_state_t st_next;
  tked_rec_t   rec;
  ev_kind_t    phase;
  logic        busy;
  logic        in_take;
  logic        out_take;
  logic        finishing;

  tked_decode u_decode (
    .st      (st),
    .rx_byte (rx_byte),
    .st_next (st_next),
    .rec     (rec)
  );

  assign out_valid  = busy;
  assign event_kind = phase;
  assign last_event = (phase == EV_UP);
  assign out_take   = busy && !out_stall;
  assign finishing  = out_take && last_event;
  assign in_stall   = busy && !finishing;
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= '0;
      busy  <= 1'b0;
      phase <= EV_DOWN;
    end else begin
      if (in_take) st <= st_next;
      if (in_take && rec.emit) begin
        busy     <= 1'b1;
        key_code <= rec.code;
        phase    <= rec.has_char ? EV_CHAR : EV_DOWN;
      end else if (finishing) begin
        busy <= 1'b0;
      end else if (out_take) begin
        unique case (phase)
          EV_CHAR: phase <= EV_DOWN;
          EV_DOWN: phase <= EV_UP;
          default: phase <= EV_UP;
        endcase
      end
    end
  end

  `TKED_ASSERT_IMP(a_take_only_free, clk, rst, in_take && busy, finishing,
                   "byte taken while events still pending")
  `TKED_ASSERT_IMP(a_last_is_up, clk, rst, out_valid && last_event, event_kind == EV_UP,
                   "final event is not key up")
  `TKED_ASSERT_IMP(a_char_printable, clk, rst, out_valid && event_kind == EV_CHAR,
                   key_code >= PrintLow && key_code <= TildeByte,
                   "char event with non-printable code")
  `TKED_ASSERT_NXT(a_seq_holds, clk, rst, out_take && !last_event,
                   out_valid && $stable(key_code),
                   "event sequence broken before key up")

endmodule

// File: tb/terminal_key_escape_decoder_tb.sv
// Self-checking testbench for terminal_key_escape_decoder: a directed table of
// bytes, then random plain bytes and well-formed and broken escape sequences, under random stalls.
// Depends on tked_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module terminal_key_escape_decoder_tb;
  import tked_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 64;
  localparam int SettleCycles = 16;
  localparam int RandomItems = 454;
  localparam int MaxReports  = 10;

  localparam logic [7:0] LetterA    = 8'h41;
  localparam logic [7:0] LetterD    = 8'h44;
  localparam logic [7:0] LetterE    = 8'h45;
  localparam logic [7:0] DigitZero  = 8'h30;
  localparam logic [7:0] DigitThree = 8'h33;
  localparam logic [7:0] DigitFour  = 8'h34;
  localparam logic [7:0] DigitFive  = 8'h35;
  localparam logic [7:0] DigitSix   = 8'h36;
  localparam logic [7:0] DigitSeven = 8'h37;
  localparam logic [7:0] DigitNine  = 8'h39;
  localparam logic [7:0] MinusByte  = 8'h2d;

  typedef struct packed {
    logic       gives_key;
    logic       has_char;
    logic [7:0] code;
  } outcome_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    outcome_t   want;
  } stim_row_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] code;
    logic       is_last;
  } key_event_t;

  typedef struct packed {
    logic       in_seq;
    logic       after_bracket;
    logic       want_low;
    logic       want_mid;
    logic       want_high;
    logic       close_mid;
    logic       close_high;
    logic       close_page;
    logic [7:0] last_digit;
  } esc_track_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] event_kind;
  logic [7:0] key_code;
  logic       last_event;

  // columns: byte, typed, gives key, has char, key code
  stim_row_t directed_tab [0:25] = '{
    {8'h00,       1'b1, 1'b0, 1'b0, 8'h00},
    {TabByte,     1'b1, 1'b1, 1'b0, TabByte},
    {PrintLow,    1'b1, 1'b1, 1'b1, PrintLow},
    {TildeByte,   1'b1, 1'b1, 1'b1, TildeByte},
    {PercentByte, 1'b1, 1'b0, 1'b0, 8'h00},
    {DelByte,     1'b1, 1'b1, 1'b0, KcBksp},
    {8'hff,       1'b1, 1'b0, 1'b0, 8'h00},
    {MinusByte,   1'b1, 1'b1, 1'b1, MinusByte},
    {EscByte,     1'b1, 1'b0, 1'b0, 8'h00},
    {BracketByte, 1'b1, 1'b0, 1'b0, 8'h00},
    {LetterA,     1'b1, 1'b1, 1'b0, KcUp},
    {EscByte,     1'b1, 1'b0, 1'b0, 8'h00},
    {BracketByte, 1'b1, 1'b0, 1'b0, 8'h00},
    {BracketByte, 1'b1, 1'b0, 1'b0, 8'h00},
    {LetterE,     1'b1, 1'b1, 1'b0, KcF1 + 8'd4},
    {EscByte,     1'b0, 1'b0, 1'b0, 8'h00},
    {BracketByte, 1'b0, 1'b0, 1'b0, 8'h00},
    {DigitOne,    1'b0, 1'b0, 1'b0, 8'h00},
    {DigitSeven,  1'b0, 1'b0, 1'b0, 8'h00},
    {TildeByte,   1'b0, 1'b0, 1'b0, 8'h00},
    {EscByte,     1'b0, 1'b0, 1'b0, 8'h00},
    {BracketByte, 1'b0, 1'b0, 1'b0, 8'h00},
    {DigitFive,   1'b0, 1'b0, 1'b0, 8'h00},
    {TildeByte,   1'b0, 1'b0, 1'b0, 8'h00},
    {EscByte,     1'b0, 1'b0, 1'b0, 8'h00},
    {8'h80,       1'b0, 1'b0, 1'b0, 8'h00}
  };

  logic [7:0] high_digits [0:3] = '{DigitZero, DigitOne, DigitThree, DigitFour};

  stim_row_t  stim_q [$];
  key_event_t expect_q [$];
  stim_row_t  cur_row = '0;
  esc_track_t esc_track = '0;

  int  cycle_count = 0;
  int  mismatches = 0;
  int  bytes_taken = 0;
  int  events_checked = 0;
  int  special_presses = 0;
  int  random_count = 0;
  int  idx;
  bit  calm = 1'b0;
  bit  hold_off_req = 1'b0;

  terminal_key_escape_decoder DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_kind (event_kind),
    .key_code   (key_code),
    .last_event (last_event)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic outcome_t predict_byte(input logic [7:0] b);
    outcome_t   res;
    logic [7:0] d;
    res = '0;
    d = esc_track.last_digit;
    if (esc_track.in_seq) begin
      if (b == BracketByte && !esc_track.after_bracket) begin
        esc_track.after_bracket = 1'b1;
      end else begin
        esc_track.after_bracket = 1'b0;
        if (b == BracketByte) begin
          esc_track.want_low = 1'b1;
        end else if (b == TildeByte) begin
          esc_track.in_seq = 1'b0;
          if (esc_track.close_mid) begin
            esc_track.close_mid = 1'b0;
            if (d >= DigitSeven && d <= DigitNine) res.code = KcF1 + 8'd5 + (d - DigitSeven);
          end else if (esc_track.close_high) begin
            esc_track.close_high = 1'b0;
            case (d)
              DigitZero:  res.code = KcF1 + 8'd8;
              DigitOne:   res.code = KcF1 + 8'd9;
              DigitThree: res.code = KcF1 + 8'd10;
              DigitFour:  res.code = KcF1 + 8'd11;
              default:    res.code = 8'h00;
            endcase
          end else if (esc_track.close_page) begin
            esc_track.close_page = 1'b0;
            esc_track.want_mid = 1'b0;
            esc_track.want_high = 1'b0;
            if (d >= DigitOne && d <= DigitSix) res.code = KcHome + (d - DigitOne);
          end
        end else if (b[6]) begin
          esc_track.in_seq = 1'b0;
          if (esc_track.want_low) begin
            esc_track.want_low = 1'b0;
            if (b >= LetterA && b <= LetterE) res.code = KcF1 + (b - LetterA);
          end else if (b >= LetterA && b <= LetterD) begin
            res.code = KcUp + (b - LetterA);
          end
        end else begin
          esc_track.last_digit = b;
          if (esc_track.want_mid) begin
            esc_track.want_mid = 1'b0;
            esc_track.close_mid = 1'b1;
          end else if (esc_track.want_high) begin
            esc_track.want_high = 1'b0;
            esc_track.close_high = 1'b1;
          end else begin
            esc_track.close_page = 1'b1;
            if (b == DigitOne) esc_track.want_mid = 1'b1;
            else if (b == DigitTwo) esc_track.want_high = 1'b1;
          end
        end
      end
      res.gives_key = (res.code != 8'h00);
    end else if (b == EscByte) begin
      esc_track.in_seq = 1'b1;
    end else if (b == TabByte || b == CrByte || b == DelByte ||
                 (b >= PrintLow && b <= TildeByte && b != PercentByte)) begin
      res.gives_key = 1'b1;
      res.has_char = (b >= PrintLow && b <= TildeByte);
      res.code = (b == DelByte) ? KcBksp : b;
    end
    return res;
  endfunction

  function automatic void queue_events(input outcome_t o);
    if (o.gives_key) begin
      if (o.has_char) expect_q.push_back({EV_CHAR, o.code, 1'b0});
      expect_q.push_back({EV_DOWN, o.code, 1'b0});
      expect_q.push_back({EV_UP, o.code, 1'b1});
    end
  endfunction

  function automatic void add_random(input logic [7:0] b);
    stim_q.push_back({b, 1'b0, 10'b0});
    random_count++;
  endfunction

  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // take a byte word, then check an event word
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        outcome_t got;
        got = predict_byte(cur_row.b);
        queue_events(cur_row.typed ? cur_row.want : got);
        bytes_taken++;
      end
      if (out_valid && !out_stall) begin
        key_event_t want;
        events_checked++;
        if (expect_q.size() == 0) begin
          flag_error($sformatf("unexpected event kind=%0d code=%0d last=%0b",
                               event_kind, key_code, last_event));
        end else begin
          want = expect_q.pop_front();
          if (event_kind !== want.kind || key_code !== want.code ||
              last_event !== want.is_last)
            flag_error($sformatf("event kind=%0d/%0d code=%0d/%0d last=%0b/%0b (exp/act)",
                                 want.kind, event_kind, want.code, key_code,
                                 want.is_last, last_event));
          if (want.kind == EV_DOWN && want.code >= KcF1) special_presses++;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk);
      end
      out_stall = calm ? 1'b0 : ($urandom_range(99) < 38);
    end
  end

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    foreach (directed_tab[i]) stim_q.push_back(directed_tab[i]);
    while (random_count < RandomItems) begin
      int pick;
      pick = $urandom_range(99);
      if (pick < 30) begin
        add_random(($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                            : 8'($urandom_range(8'h20, 8'h7f)));
      end else if (pick < 85) begin
        add_random(EscByte);
        add_random(BracketByte);
        case ($urandom_range(4))
          0: add_random(8'($urandom_range(LetterA, LetterD)));
          1: begin
            add_random(BracketByte);
            add_random(8'($urandom_range(LetterA, LetterE)));
          end
          2: begin
            add_random(DigitOne);
            add_random(8'($urandom_range(DigitSeven, DigitNine)));
            add_random(TildeByte);
          end
          3: begin
            add_random(DigitTwo);
            add_random(high_digits[2'($urandom_range(3))]);
            add_random(TildeByte);
          end
          default: begin
            add_random(8'($urandom_range(DigitOne, DigitSix)));
            add_random(TildeByte);
          end
        endcase
      end else begin
        add_random(EscByte);
        repeat ($urandom_range(1, 4))
          add_random($urandom_range(1) ? 8'($urandom_range(8'h30, 8'h7e))
                                       : 8'($urandom_range(255)));
      end
    end

    repeat (9) @(negedge clk);
    rst = 1'b0;

    for (idx = 0; idx < stim_q.size(); idx++) begin
      calm = (idx >= 200 && idx < 300);
      if (idx == 120) hold_off_req = 1'b1;
      if (idx == 380) begin
        while (expect_q.size() != 0) begin
          in_valid = 1'b0;
          @(negedge clk);
        end
      end
      while (!calm && $urandom_range(99) < 38) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
      in_valid = 1'b1;
      rx_byte = stim_q[idx].b;
      cur_row = stim_q[idx];
      @(posedge clk);
      while (in_stall) @(posedge clk);
      @(negedge clk);
    end
    in_valid = 1'b0;
    calm = 1'b0;

    while (expect_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("Sent %0d bytes (%0d from the directed table), checked %0d events.",
             bytes_taken, $size(directed_tab), events_checked);
    $display("Covered plain keys, %0d special-key presses, broken sequences and stalls.",
             special_presses);
    if (mismatches == 0 && expect_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
